// File: rtl/tsp_ci_pkg.sv
// Shared types and constants for the cheapest-insertion tour builder.
package tsp_ci_pkg;

   localparam int MAX_CITIES = 32;
   localparam int IDX_W      = $clog2(MAX_CITIES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int COORD_W    = 20;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int DIST_W     = 17;
   localparam int TOT_W      = 22;
   localparam int CITY_W     = 6;
   localparam int TOUR_DEPTH = MAX_CITIES + 2;
   localparam int TOUR_AW    = $clog2(TOUR_DEPTH);
   localparam int DADDR_W    = 2 * IDX_W;
   localparam int COST_W     = DIST_W + 2;

   // request to the distance unit
   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
   } eu_req_type;

   // reply from the distance unit
   typedef struct packed {
      logic              done;
      logic [DIST_W-1:0] gap;
   } eu_rsp_type;

   typedef enum logic [2:0] {
      EU_IDLE,
      EU_SQX,
      EU_SQY,
      EU_ROOT,
      EU_DONE
   } eu_state_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_DI,
      ST_DJ,
      ST_DDIF,
      ST_DWAIT,
      ST_SD0,
      ST_SD0C,
      ST_SDRD,
      ST_SDEV,
      ST_SEEDW,
      ST_CSCAN,
      ST_ARD,
      ST_TRD,
      ST_DAC,
      ST_DBC,
      ST_DAB,
      ST_CMP,
      ST_SHRD,
      ST_SHWR,
      ST_TOTRD,
      ST_TOTD,
      ST_TOTACC,
      ST_OUTRD,
      ST_OUTLD,
      ST_OUTW
   } tci_state_type;

endpackage

// File: rtl/tsp_ci_euclid.sv
// Iterative distance unit: squares with one multiplier, then a bit-pair square root.
module tsp_ci_euclid (
   input  logic                   clock,
   input  logic                   reset,
   input  tsp_ci_pkg::eu_req_type req,
   output tsp_ci_pkg::eu_rsp_type rsp
);

   tsp_ci_pkg::eu_state_type state_ff, state_in;

   logic [tsp_ci_pkg::DIFF_W-1:0] ax_ff, ay_ff;
   logic [tsp_ci_pkg::SQ_W-1:0]   v_ff, res_ff, bit_ff;
   logic [tsp_ci_pkg::DIFF_W-1:0] mul_in;
   logic [tsp_ci_pkg::SQ_W-1:0]   prod;
   logic [tsp_ci_pkg::SQ_W:0]     trial;
   logic                          fits;

   // shared multiplier and root step
   assign mul_in = (state_ff == tsp_ci_pkg::EU_SQX) ? ax_ff : ay_ff;
   assign prod   = mul_in * mul_in;
   assign trial  = {1'b0, res_ff} + {1'b0, bit_ff};
   assign fits   = ({1'b0, v_ff} >= trial);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsp_ci_pkg::EU_IDLE: if (req.start) state_in = tsp_ci_pkg::EU_SQX;
         tsp_ci_pkg::EU_SQX:  state_in = tsp_ci_pkg::EU_SQY;
         tsp_ci_pkg::EU_SQY:  state_in = tsp_ci_pkg::EU_ROOT;
         tsp_ci_pkg::EU_ROOT: if (bit_ff == '0) state_in = tsp_ci_pkg::EU_DONE;
         tsp_ci_pkg::EU_DONE: state_in = tsp_ci_pkg::EU_IDLE;
         default:             state_in = tsp_ci_pkg::EU_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp.done = (state_ff == tsp_ci_pkg::EU_DONE);
      rsp.gap  = res_ff[tsp_ci_pkg::DIST_W+3:4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsp_ci_pkg::EU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         tsp_ci_pkg::EU_IDLE: begin
            ax_ff <= req.dx[tsp_ci_pkg::DIFF_W-1] ? (~req.dx + 1'b1) : req.dx;
            ay_ff <= req.dy[tsp_ci_pkg::DIFF_W-1] ? (~req.dy + 1'b1) : req.dy;
         end
         tsp_ci_pkg::EU_SQX: begin
            v_ff <= prod;
         end
         tsp_ci_pkg::EU_SQY: begin
            v_ff   <= v_ff + prod;
            res_ff <= '0;
            bit_ff <= {2'b01, {(tsp_ci_pkg::SQ_W-2){1'b0}}};
         end
         tsp_ci_pkg::EU_ROOT: begin
            if (bit_ff != '0) begin
               if (fits) begin
                  v_ff   <= v_ff - trial[tsp_ci_pkg::SQ_W-1:0];
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// File: rtl/tsp_cheapest_insertion_top.sv
// Top level: city store, distance table, tour memory and the insertion sequencer.
//
// Cities arrive one word each on the req_ channel (x, y in signed Q16.4) and are
// numbered from 1 in arrival order; cities beyond 32 are dropped. Each non-final
// word is accepted while loading and gives no result. The word with req_last_city set
// starts a run and req_ready stays low until the run's last result is taken.
// A run builds the full distance table, one entry per ordered pair from the
// iterative square-root unit, picks three seed cities, then inserts cities one
// at a time; each trial of a city at a tour position reads three distances in
// turn on the single distance-table read port. The tour length pass and emission
// follow.
// Results leave on the rsp_ channel, one tour city per word, the first city
// repeated at the end, with the length on the word marked rsp_last_of_run.
// Fewer than three cities give one word with rsp_too_few set.
// A stalled receiver simply holds the sequencer: each result waits in its output
// register until rsp_ready. Synchronous reset returns the block to loading with
// no cities stored; no clearing pass is needed.
module tsp_cheapest_insertion_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [tsp_ci_pkg::COORD_W-1:0]   req_x_coord,
   input  logic signed [tsp_ci_pkg::COORD_W-1:0]   req_y_coord,
   input  logic                                    req_last_city,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [tsp_ci_pkg::CITY_W-1:0]           rsp_city,
   output logic [tsp_ci_pkg::TOT_W-1:0]            rsp_total_distance,
   output logic                                    rsp_last_of_run,
   output logic                                    rsp_too_few
);

   localparam int IW = tsp_ci_pkg::IDX_W;
   localparam int CW = tsp_ci_pkg::CNT_W;
   localparam int TW = tsp_ci_pkg::TOUR_AW;

   tsp_ci_pkg::tci_state_type state_ff, state_in;

   // memories
   logic signed [tsp_ci_pkg::COORD_W-1:0] x_mem [tsp_ci_pkg::MAX_CITIES];
   logic signed [tsp_ci_pkg::COORD_W-1:0] y_mem [tsp_ci_pkg::MAX_CITIES];
   logic [tsp_ci_pkg::DIST_W-1:0] d_mem [tsp_ci_pkg::MAX_CITIES * tsp_ci_pkg::MAX_CITIES];
   logic [IW-1:0] t_mem [tsp_ci_pkg::TOUR_DEPTH];

   logic signed [tsp_ci_pkg::COORD_W-1:0] x_rd_ff, y_rd_ff;
   logic [tsp_ci_pkg::DIST_W-1:0]         d_rd_ff;
   logic [IW-1:0]                         t_rd_ff;

   // memory controls
   logic                               xy_we;
   logic [IW-1:0]                      xy_raddr;
   logic                               d_we;
   logic [tsp_ci_pkg::DADDR_W-1:0]     d_waddr, d_raddr;
   logic                               t_we;
   logic [TW-1:0]                      t_waddr, t_raddr;
   logic [IW-1:0]                      t_wdata;

   // sequencer registers
   logic [CW-1:0] count_ff, n_ff, i_ff, j_ff, c_ff;
   logic [TW-1:0] len_ff, p_ff, k_ff, cpos_ff, best_pos_ff;
   logic [CW-1:0] rem_ff;
   logic signed [tsp_ci_pkg::COORD_W-1:0] xi_ff, yi_ff, wx_ff, ny_ff, sy_ff;
   logic [IW-1:0] pn_ff, ps_ff, pw_ff, a_ff, b_ff, best_c_ff, prev_ff;
   logic [tsp_ci_pkg::MAX_CITIES-1:0] flags_ff;
   logic signed [tsp_ci_pkg::COST_W-1:0] acc_ff, cbest_ff, best_ff, cost, newc;
   logic [TW-1:0] newpos;
   logic have_ff, take_pos;
   logic [tsp_ci_pkg::TOT_W-1:0] total_ff;

   logic req_acc, rsp_acc, room;
   logic [CW-1:0] count_nx;

   tsp_ci_pkg::eu_req_type eu_req;
   tsp_ci_pkg::eu_rsp_type eu_rsp;

   tsp_ci_euclid u_euclid (
      .clock (clock),
      .reset (reset),
      .req   (eu_req),
      .rsp   (eu_rsp)
   );

   assign req_ready = (state_ff == tsp_ci_pkg::ST_LOAD);
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign room      = (count_ff < CW'(tsp_ci_pkg::MAX_CITIES));
   assign count_nx  = room ? count_ff + 1'b1 : count_ff;

   // insertion cost of the current position
   assign cost     = acc_ff - $signed({2'b00, d_rd_ff});
   assign take_pos = (p_ff == '0) || (cost < cbest_ff);
   assign newc     = take_pos ? cost : cbest_ff;
   assign newpos   = take_pos ? p_ff : cpos_ff;

   assign eu_req.start = (state_ff == tsp_ci_pkg::ST_DDIF);
   assign eu_req.dx = {xi_ff[tsp_ci_pkg::COORD_W-1], xi_ff}
                    - {x_rd_ff[tsp_ci_pkg::COORD_W-1], x_rd_ff};
   assign eu_req.dy = {yi_ff[tsp_ci_pkg::COORD_W-1], yi_ff}
                    - {y_rd_ff[tsp_ci_pkg::COORD_W-1], y_rd_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsp_ci_pkg::ST_LOAD: begin
            if (req_acc && req_last_city) begin
               state_in = (count_nx < CW'(3)) ? tsp_ci_pkg::ST_OUTW : tsp_ci_pkg::ST_DI;
            end
         end
         tsp_ci_pkg::ST_DI:    state_in = tsp_ci_pkg::ST_DJ;
         tsp_ci_pkg::ST_DJ:    state_in = tsp_ci_pkg::ST_DDIF;
         tsp_ci_pkg::ST_DDIF:  state_in = tsp_ci_pkg::ST_DWAIT;
         tsp_ci_pkg::ST_DWAIT: begin
            if (eu_rsp.done) begin
               if (j_ff == n_ff - 1'b1 && i_ff == n_ff - 1'b1) state_in = tsp_ci_pkg::ST_SD0;
               else state_in = tsp_ci_pkg::ST_DI;
            end
         end
         tsp_ci_pkg::ST_SD0:  state_in = tsp_ci_pkg::ST_SD0C;
         tsp_ci_pkg::ST_SD0C: state_in = tsp_ci_pkg::ST_SDRD;
         tsp_ci_pkg::ST_SDRD: begin
            state_in = (c_ff == n_ff) ? tsp_ci_pkg::ST_SEEDW : tsp_ci_pkg::ST_SDEV;
         end
         tsp_ci_pkg::ST_SDEV: state_in = tsp_ci_pkg::ST_SDRD;
         tsp_ci_pkg::ST_SEEDW: begin
            if (k_ff == TW'(2)) begin
               state_in = (n_ff - 1'b1 - CW'(ps_ff != pn_ff)
                           - CW'(pw_ff != pn_ff && pw_ff != ps_ff) == '0)
                          ? tsp_ci_pkg::ST_TOTRD : tsp_ci_pkg::ST_CSCAN;
            end
         end
         tsp_ci_pkg::ST_CSCAN: begin
            if (c_ff == n_ff) state_in = tsp_ci_pkg::ST_SHRD;
            else if (flags_ff[c_ff[IW-1:0]]) state_in = tsp_ci_pkg::ST_ARD;
         end
         tsp_ci_pkg::ST_ARD: state_in = tsp_ci_pkg::ST_TRD;
         tsp_ci_pkg::ST_TRD: state_in = tsp_ci_pkg::ST_DAC;
         tsp_ci_pkg::ST_DAC: state_in = tsp_ci_pkg::ST_DBC;
         tsp_ci_pkg::ST_DBC: state_in = tsp_ci_pkg::ST_DAB;
         tsp_ci_pkg::ST_DAB: state_in = tsp_ci_pkg::ST_CMP;
         tsp_ci_pkg::ST_CMP: begin
            state_in = (p_ff == len_ff - 1'b1) ? tsp_ci_pkg::ST_CSCAN : tsp_ci_pkg::ST_TRD;
         end
         tsp_ci_pkg::ST_SHRD: begin
            if (k_ff == best_pos_ff) begin
               state_in = (rem_ff == CW'(1)) ? tsp_ci_pkg::ST_TOTRD : tsp_ci_pkg::ST_CSCAN;
            end else begin
               state_in = tsp_ci_pkg::ST_SHWR;
            end
         end
         tsp_ci_pkg::ST_SHWR:  state_in = tsp_ci_pkg::ST_SHRD;
         tsp_ci_pkg::ST_TOTRD: state_in = tsp_ci_pkg::ST_TOTD;
         tsp_ci_pkg::ST_TOTD: begin
            state_in = (k_ff == '0) ? tsp_ci_pkg::ST_TOTRD : tsp_ci_pkg::ST_TOTACC;
         end
         tsp_ci_pkg::ST_TOTACC: begin
            state_in = (k_ff == len_ff) ? tsp_ci_pkg::ST_OUTRD : tsp_ci_pkg::ST_TOTRD;
         end
         tsp_ci_pkg::ST_OUTRD: state_in = tsp_ci_pkg::ST_OUTLD;
         tsp_ci_pkg::ST_OUTLD: state_in = tsp_ci_pkg::ST_OUTW;
         tsp_ci_pkg::ST_OUTW: begin
            if (rsp_ready) begin
               state_in = (k_ff == len_ff) ? tsp_ci_pkg::ST_LOAD : tsp_ci_pkg::ST_OUTRD;
            end
         end
         default: state_in = tsp_ci_pkg::ST_LOAD;
      endcase
   end

   // memory addresses and write enables
   always_comb begin
      xy_we    = req_acc && room;
      xy_raddr = '0;
      d_we     = 1'b0;
      d_waddr  = {i_ff[IW-1:0], j_ff[IW-1:0]};
      d_raddr  = '0;
      t_we     = 1'b0;
      t_waddr  = k_ff;
      t_wdata  = t_rd_ff;
      t_raddr  = '0;
      case (state_ff)
         tsp_ci_pkg::ST_DI:    xy_raddr = i_ff[IW-1:0];
         tsp_ci_pkg::ST_DJ:    xy_raddr = j_ff[IW-1:0];
         tsp_ci_pkg::ST_DWAIT: d_we = eu_rsp.done;
         tsp_ci_pkg::ST_SDRD:  xy_raddr = c_ff[IW-1:0];
         tsp_ci_pkg::ST_SEEDW: begin
            t_we = 1'b1;
            if (k_ff == '0) t_wdata = pn_ff;
            else if (k_ff == TW'(1)) t_wdata = ps_ff;
            else t_wdata = pw_ff;
         end
         tsp_ci_pkg::ST_ARD: t_raddr = len_ff - 1'b1;
         tsp_ci_pkg::ST_TRD: t_raddr = p_ff;
         tsp_ci_pkg::ST_DAC: d_raddr = {a_ff, c_ff[IW-1:0]};
         tsp_ci_pkg::ST_DBC: d_raddr = {b_ff, c_ff[IW-1:0]};
         tsp_ci_pkg::ST_DAB: d_raddr = {a_ff, b_ff};
         tsp_ci_pkg::ST_SHRD: begin
            t_raddr = k_ff - 1'b1;
            if (k_ff == best_pos_ff) begin
               t_we    = 1'b1;
               t_wdata = best_c_ff;
            end
         end
         tsp_ci_pkg::ST_SHWR:  t_we = 1'b1;
         tsp_ci_pkg::ST_TOTRD: t_raddr = (k_ff == len_ff) ? '0 : k_ff;
         tsp_ci_pkg::ST_TOTD:  d_raddr = {prev_ff, t_rd_ff};
         tsp_ci_pkg::ST_OUTRD: t_raddr = (k_ff == len_ff) ? '0 : k_ff;
         default: begin
         end
      endcase
   end

   // memories, read data registered
   always_ff @(posedge clock) begin
      if (xy_we) begin
         x_mem[count_ff[IW-1:0]] <= req_x_coord;
         y_mem[count_ff[IW-1:0]] <= req_y_coord;
      end
      x_rd_ff <= x_mem[xy_raddr];
      y_rd_ff <= y_mem[xy_raddr];
   end

   always_ff @(posedge clock) begin
      if (d_we) d_mem[d_waddr] <= eu_rsp.gap;
      d_rd_ff <= d_mem[d_raddr];
   end

   always_ff @(posedge clock) begin
      if (t_we) t_mem[t_waddr] <= t_wdata;
      t_rd_ff <= t_mem[t_raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tsp_ci_pkg::ST_LOAD;
         count_ff  <= '0;
         flags_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_acc) count_ff <= req_last_city ? '0 : count_nx;
         if (state_ff == tsp_ci_pkg::ST_SEEDW && k_ff == TW'(2)) begin
            for (int f = 0; f < tsp_ci_pkg::MAX_CITIES; f++) begin
               flags_ff[f] <= (CW'(f) < n_ff) && (IW'(f) != pn_ff)
                              && (IW'(f) != ps_ff) && (IW'(f) != pw_ff);
            end
         end
         if (state_ff == tsp_ci_pkg::ST_SHRD && k_ff == best_pos_ff) begin
            flags_ff[best_c_ff] <= 1'b0;
         end
         if (state_ff == tsp_ci_pkg::ST_OUTLD) rsp_valid <= 1'b1;
         else if (state_ff == tsp_ci_pkg::ST_LOAD && req_acc && req_last_city
                  && count_nx < CW'(3)) rsp_valid <= 1'b1;
         else if (rsp_acc) rsp_valid <= 1'b0;
      end
   end

   // sequencer datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         tsp_ci_pkg::ST_LOAD: begin
            n_ff <= count_nx;
            i_ff <= '0;
            j_ff <= '0;
            len_ff <= '0;
            k_ff <= '0;
            rsp_city           <= '0;
            rsp_total_distance <= '0;
            rsp_last_of_run    <= 1'b1;
            rsp_too_few        <= 1'b1;
         end
         tsp_ci_pkg::ST_DJ: begin
            xi_ff <= x_rd_ff;
            yi_ff <= y_rd_ff;
         end
         tsp_ci_pkg::ST_DWAIT: begin
            if (eu_rsp.done) begin
               if (j_ff == n_ff - 1'b1) begin
                  j_ff <= '0;
                  i_ff <= i_ff + 1'b1;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
         end
         tsp_ci_pkg::ST_SD0C: begin
            wx_ff <= x_rd_ff;
            ny_ff <= y_rd_ff;
            sy_ff <= y_rd_ff;
            pn_ff <= '0;
            ps_ff <= '0;
            pw_ff <= '0;
            c_ff  <= CW'(1);
            k_ff  <= '0;
         end
         tsp_ci_pkg::ST_SDEV: begin
            // seed rule: west first, then north, then south
            if (x_rd_ff < wx_ff) begin
               wx_ff <= x_rd_ff;
               pw_ff <= c_ff[IW-1:0];
            end else if (y_rd_ff > ny_ff || (pn_ff == pw_ff && pn_ff == '0)) begin
               ny_ff <= y_rd_ff;
               pn_ff <= c_ff[IW-1:0];
            end else if (y_rd_ff < sy_ff || (ps_ff == pw_ff && ps_ff == '0)) begin
               sy_ff <= y_rd_ff;
               ps_ff <= c_ff[IW-1:0];
            end
            c_ff <= c_ff + 1'b1;
         end
         tsp_ci_pkg::ST_SEEDW: begin
            if (k_ff == TW'(2)) begin
               len_ff  <= TW'(3);
               rem_ff  <= n_ff - 1'b1 - CW'(ps_ff != pn_ff)
                          - CW'(pw_ff != pn_ff && pw_ff != ps_ff);
               c_ff    <= '0;
               have_ff <= 1'b0;
               total_ff <= '0;
               k_ff    <= '0;
            end else begin
               k_ff <= k_ff + 1'b1;
            end
         end
         tsp_ci_pkg::ST_CSCAN: begin
            if (c_ff == n_ff) k_ff <= len_ff;
            else if (!flags_ff[c_ff[IW-1:0]]) c_ff <= c_ff + 1'b1;
            p_ff <= '0;
         end
         tsp_ci_pkg::ST_TRD: begin
            if (p_ff == '0) a_ff <= t_rd_ff;
         end
         tsp_ci_pkg::ST_DAC: b_ff <= t_rd_ff;
         tsp_ci_pkg::ST_DBC: acc_ff <= $signed({2'b00, d_rd_ff});
         tsp_ci_pkg::ST_DAB: acc_ff <= acc_ff + $signed({2'b00, d_rd_ff});
         tsp_ci_pkg::ST_CMP: begin
            cbest_ff <= newc;
            cpos_ff  <= newpos;
            a_ff     <= b_ff;
            p_ff     <= p_ff + 1'b1;
            if (p_ff == len_ff - 1'b1) begin
               // city finished: first minimum across cities wins
               if (!have_ff || newc < best_ff) begin
                  have_ff     <= 1'b1;
                  best_ff     <= newc;
                  best_c_ff   <= c_ff[IW-1:0];
                  best_pos_ff <= newpos;
               end
               c_ff <= c_ff + 1'b1;
            end
         end
         tsp_ci_pkg::ST_SHRD: begin
            if (k_ff == best_pos_ff) begin
               len_ff  <= len_ff + 1'b1;
               rem_ff  <= rem_ff - 1'b1;
               c_ff    <= '0;
               have_ff <= 1'b0;
               k_ff    <= '0;
            end
         end
         tsp_ci_pkg::ST_SHWR: k_ff <= k_ff - 1'b1;
         tsp_ci_pkg::ST_TOTD: begin
            prev_ff <= t_rd_ff;
            if (k_ff == '0) k_ff <= k_ff + 1'b1;
         end
         tsp_ci_pkg::ST_TOTACC: begin
            total_ff <= total_ff + tsp_ci_pkg::TOT_W'(d_rd_ff);
            k_ff     <= (k_ff == len_ff) ? '0 : k_ff + 1'b1;
         end
         tsp_ci_pkg::ST_OUTLD: begin
            rsp_city           <= {1'b0, t_rd_ff} + 1'b1;
            rsp_last_of_run    <= (k_ff == len_ff);
            rsp_total_distance <= (k_ff == len_ff) ? total_ff : '0;
            rsp_too_few        <= 1'b0;
         end
         tsp_ci_pkg::ST_OUTW: begin
            if (rsp_ready && k_ff != len_ff) k_ff <= k_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // checks
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_few_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_few |-> rsp_last_of_run && rsp_city == '0)
      else $error("too-few word malformed");

   a_total_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_total_distance == '0)
      else $error("length shown before last word");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_last_of_run |=> req_ready)
      else $error("not back to loading after run");

endmodule

// File: verif/testbench.sv
// Testbench for the cheapest-insertion tour builder: directed and random city sets.
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_CITIES = tsp_ci_pkg::MAX_CITIES;
   localparam int COORD_W    = tsp_ci_pkg::COORD_W;
   localparam int CITY_W     = tsp_ci_pkg::CITY_W;
   localparam int TOT_W      = tsp_ci_pkg::TOT_W;

   localparam int CYCLE_LIMIT = 4000000;

   // one expected tour word
   typedef struct {
      logic [CITY_W-1:0] city;
      logic [TOT_W-1:0]  total;
      logic              last;
      logic              few;
   } tour_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_x_coord = '0;
   logic signed [COORD_W-1:0] req_y_coord = '0;
   logic req_last_city = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CITY_W-1:0] rsp_city;
   logic [TOT_W-1:0]  rsp_total_distance;
   logic rsp_last_of_run;
   logic rsp_too_few;

   // loaded city set, held by the predictor
   logic signed [COORD_W-1:0] set_x [MAX_CITIES];
   logic signed [COORD_W-1:0] set_y [MAX_CITIES];
   int unsigned set_count = 0;

   tour_word_type tour_words_due[$];
   int unsigned fail_count = 0;
   int unsigned words_seen = 0;
   int unsigned runs_done = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit hold_go = 1'b0;
   bit recv_hold = 1'b0;

   tsp_cheapest_insertion_top dut (.*);

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  tour_words_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // integer square root, bit by bit
   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // floor of the Euclidean distance in whole units
   function automatic int city_gap(int unsigned a, int unsigned b);
      longint dx, dy;
      if (a == b) return 0;
      dx = longint'(set_x[a]) - longint'(set_x[b]);
      dy = longint'(set_y[a]) - longint'(set_y[b]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return int'(int_root(longint'(dx * dx + dy * dy)) >> 4);
   endfunction

   // builds the tour for the loaded set and queues its words
   task automatic predict_tour();
      int unsigned n, pn, ps, pw, len, remaining, best_c, best_pos, cpos, total;
      logic signed [COORD_W-1:0] wx, ny, sy;
      int unsigned tour [MAX_CITIES+2];
      bit unvisited [MAX_CITIES];
      bit have;
      int best, cbest, v, a, b;
      tour_word_type w;
      n = set_count;
      set_count = 0;
      if (n < 3) begin
         w = '{city: '0, total: '0, last: 1'b1, few: 1'b1};
         tour_words_due = {tour_words_due, w};
         return;
      end
      // seeds: west, north, south picks
      pn = 0; ps = 0; pw = 0;
      wx = set_x[0]; ny = set_y[0]; sy = set_y[0];
      for (int unsigned c = 1; c < n; c++) begin
         if (set_x[c] < wx) begin
            wx = set_x[c]; pw = c;
         end else if (set_y[c] > ny || (pn == pw && pn == 0)) begin
            ny = set_y[c]; pn = c;
         end else if (set_y[c] < sy || (ps == pw && ps == 0)) begin
            sy = set_y[c]; ps = c;
         end
      end
      tour[0] = pn; tour[1] = ps; tour[2] = pw;
      len = 3;
      remaining = 0;
      for (int unsigned i = 0; i < MAX_CITIES; i++) begin
         unvisited[i] = (i < n) && i != pn && i != ps && i != pw;
         if (unvisited[i]) remaining++;
      end
      // cheapest insertion, first minimum wins
      while (remaining > 0) begin
         have = 0; best = 0; best_c = 0; best_pos = 0;
         for (int unsigned c = 0; c < n; c++) begin
            if (!unvisited[c]) continue;
            cbest = 0; cpos = 0;
            for (int unsigned p = 0; p < len; p++) begin
               a = tour[p == 0 ? len - 1 : p - 1];
               b = tour[p];
               v = city_gap(a, c) + city_gap(b, c) - city_gap(a, b);
               if (p == 0 || v < cbest) begin
                  cbest = v; cpos = p;
               end
            end
            if (!have || cbest < best) begin
               have = 1; best = cbest; best_c = c; best_pos = cpos;
            end
         end
         for (int unsigned k = len; k > best_pos; k--) tour[k] = tour[k-1];
         tour[best_pos] = best_c;
         len++;
         unvisited[best_c] = 0;
         remaining--;
      end
      tour[len] = tour[0];
      len++;
      total = 0;
      for (int unsigned k = 1; k < len; k++) total += city_gap(tour[k], tour[k-1]);
      for (int unsigned k = 0; k < len; k++) begin
         w.city  = CITY_W'(tour[k] + 1);
         w.total = (k + 1 == len) ? TOT_W'(total) : '0;
         w.last  = (k + 1 == len);
         w.few   = 1'b0;
         tour_words_due = {tour_words_due, w};
      end
   endtask

   // offers one city word and waits for it to be taken
   task automatic send_city(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_x_coord   <= x;
      req_y_coord   <= y;
      req_last_city <= last;
      do @(posedge clock); while (!req_ready);
      if (set_count < MAX_CITIES) begin
         set_x[set_count] = x;
         set_y[set_count] = y;
         set_count++;
      end
      if (last) begin
         predict_tour();
         runs_done++;
      end
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(int unsigned style);
      case (style)
         0: return COORD_W'($urandom);
         1: return COORD_W'(int'($urandom_range(400)) - 200);
         default: return $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
      endcase
   endfunction

   // sends a set of n random cities
   task automatic send_set(int unsigned n, int unsigned style);
      for (int unsigned i = 0; i < n; i++)
         send_city(rand_coord(style), rand_coord(style), i == n - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tour_words_due.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d (word %0d)", what, got, want,
               words_seen);
      fail_count++;
   endtask

   // long receiver hold-off, counted here
   initial begin
      wait (hold_go);
      @(posedge clock);
      recv_hold <= 1'b1;
      repeat (3000) @(posedge clock);
      recv_hold <= 1'b0;
   end

   // result checker and receiver stalls
   always @(posedge clock) begin
      tour_word_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (tour_words_due.size() == 0) begin
               report_mismatch("unexpected word, city", rsp_city, 0);
            end else begin
               w = tour_words_due.pop_front();
               if (rsp_city !== w.city) report_mismatch("city", rsp_city, w.city);
               if (rsp_total_distance !== w.total)
                  report_mismatch("total_distance", rsp_total_distance, w.total);
               if (rsp_last_of_run !== w.last)
                  report_mismatch("last_of_run", rsp_last_of_run, w.last);
               if (rsp_too_few !== w.few) report_mismatch("too_few", rsp_too_few, w.few);
            end
         end
         if (recv_hold) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // fewer than three cities
   task automatic test_too_few();
      send_city(20'sd0, 20'sd0, 1'b1);
      send_city(20'sh7FFFF, 20'sh80000, 1'b0);
      send_city(20'sh80000, 20'sh7FFFF, 1'b1);
      drain();
   endtask

   // corner coordinates and coincident cities
   task automatic test_extremes();
      send_city(20'sh80000, 20'sh80000, 1'b0);
      send_city(20'sh7FFFF, 20'sh7FFFF, 1'b0);
      send_city(20'sh80000, 20'sh7FFFF, 1'b1);
      send_city(20'sh7FFFF, 20'sh80000, 1'b0);
      send_city(20'sh80000, 20'sh80000, 1'b0);
      send_city(20'sh7FFFF, 20'sh7FFFF, 1'b0);
      send_city(20'sh80000, 20'sh7FFFF, 1'b0);
      send_city(20'sd0, 20'sd0, 1'b1);
      // all the same point: seeds coincide and every cost ties
      for (int i = 0; i < 4; i++) send_city(20'sd160, -20'sd160, i == 3);
      // ties on x along a line
      for (int i = 0; i < 5; i++) send_city(20'sd0, 20'(i * 16), i == 4);
      drain();
   endtask

   // random sets, mostly small, a few tiny ones
   task automatic test_random_sets(int unsigned items);
      int unsigned sent, n;
      sent = 0;
      while (sent < items) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         send_set(n, $urandom_range(9) < 6 ? 0 : ($urandom_range(3) == 0 ? 2 : 1));
         sent += n;
      end
      drain();
   endtask

   // more cities than the store holds; the surplus is dropped
   task automatic test_overflow();
      send_set(MAX_CITIES + 2, 0);
      drain();
   endtask

   // long receiver hold-off while further sets are offered
   task automatic test_backpressure();
      hold_go = 1'b1;
      send_set(6, 0);
      send_set(4, 1);
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 28; recv_idle_pct = 88;
      test_too_few();
      test_extremes();
      test_random_sets(20);
      test_backpressure();
      send_idle_pct = 88; recv_idle_pct = 28;
      test_random_sets(12);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random_sets(8);
      test_overflow();
      repeat (50) @(posedge clock);
      $display("covered %0d tours and %0d result words, including too-few, coincident,",
               runs_done, words_seen);
      $display("corner-coordinate, full-store and overflow sets under stalls");
      if (fail_count == 0 && tour_words_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d words missing", fail_count, tour_words_due.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/tsp_ci_pkg.sv
rtl/tsp_ci_euclid.sv
rtl/tsp_cheapest_insertion_top.sv
verif/testbench.sv
